[sv/pbim_pkg.sv]
// ----------------------------------------------------------------------------
// pbim_pkg
// Shared types and constants for the palette builder and index mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pbim_pkg;

    localparam int COMP_W     = 8;
    localparam int COLOR_W    = 3 * COMP_W;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [IN_USER_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_LEARN = 2'd1,
        KIND_MAP   = 2'd2
    } t_kind;

    typedef logic [COLOR_W-1:0] t_color;

    typedef struct packed {
        logic [COUNT_W-1:0] palette_count;
        logic               added;
        logic [INDEX_W-1:0] color_index;
        logic               found;
    } t_result;

endpackage

`default_nettype wire

[sv/pbim_ram.sv]
// ----------------------------------------------------------------------------
// pbim_ram
// Palette color store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbim_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_wr_en,
    input  wire logic [ADDR_W-1:0]       i_wr_addr,
    input  wire pbim_pkg::t_color        i_wr_data,
    input  wire logic                    i_rd_en,
    input  wire logic [ADDR_W-1:0]       i_rd_addr,
    output      pbim_pkg::t_color        o_rd_data
);
    import pbim_pkg::*;

    t_color r_mem [DEPTH];
    t_color r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/palette_build_and_index_map.sv]
// A load or an ignored kind goes from the transfer straight to the result state; a learn or
// map with a nonempty palette first searches the entries below the count, from index 0,
// stopping at the first match; the memory read port checks one entry per cycle. The result
// state waits out any output stall, and a new item is taken only after it has been left.
// Reset: synchronous, active low; clears the entry count, the state and the output valid.
// Palette memory contents are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
// palette_build_and_index_map
// Builds a palette of RGB colors and maps pixel colors to palette indices.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_build_and_index_map #(
    parameter int MAX_COLORS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [pbim_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind [1:0]
    input  wire logic [pbim_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // found [0], color_index [4:1], added [5], palette_count [10:6], zero [15:11]
    output      logic [pbim_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import pbim_pkg::*;

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int CNT_W = $clog2(MAX_COLORS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

    t_state                      r_state, n_state;
    logic [IN_USER_W-1:0]        r_kind, n_kind;
    t_color                      r_color, n_color;
    logic [IDX_W-1:0]            r_chk, n_chk;
    logic                        r_found, n_found;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    t_result                     r_out, n_out;

    logic                        accept;
    logic                        out_free;
    logic                        hit;
    logic                        last;
    logic                        room;
    logic                        add;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    t_color                      rd_data;

    pbim_ram #(
        .DEPTH  (MAX_COLORS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (add),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (r_color),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign hit           = (rd_data == r_color);
    assign last          = (r_chk == IDX_W'(r_count - CNT_W'(1)));
    assign room          = (r_count < CNT_W'(MAX_COLORS));

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_color     = r_color;
        n_chk       = r_chk;
        n_found     = r_found;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = '0;
        add         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = s_axis_tuser;
                    n_color = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
                    n_found = 1'b0;
                    n_chk   = '0;
                    if ((s_axis_tuser == KIND_LEARN || s_axis_tuser == KIND_MAP)
                        && r_count != '0) begin
                        rd_en   = 1'b1;
                        n_state = ST_SEARCH;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SEARCH: begin
                // read data holds the entry at r_chk
                if (hit) begin
                    n_found = 1'b1;
                    n_state = ST_RESULT;
                end else if (last) begin
                    n_chk   = '0;
                    n_state = ST_RESULT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_chk + IDX_W'(1);
                    n_chk   = rd_addr;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    add = room && (r_kind == KIND_LOAD || (r_kind == KIND_LEARN && !r_found));
                    n_count                 = r_count + CNT_W'(add);
                    n_out_valid             = 1'b1;
                    n_out.found             = r_found;
                    n_out.color_index       = INDEX_W'(r_chk);
                    n_out.added             = add;
                    n_out.palette_count     = COUNT_W'(n_count);
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind  <= n_kind;
        r_color <= n_color;
        r_chk   <= n_chk;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

endmodule

`default_nettype wire

[sv/pbim_checker.sv]
// ----------------------------------------------------------------------------
// pbim_checker
// Port-level checks for the palette builder and index mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module pbim_checker #(
    parameter int MAX_COLORS = 16
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [pbim_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input wire logic [pbim_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [pbim_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import pbim_pkg::*;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                     && (s_axis_tuser == s_axis_tuser);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: ready drops after each input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    // a result never both matches and appends
    a_found_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[5]))
        else $error("found and added both set");

    // no match means index zero
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == '0)
        else $error("nonzero index without a match");

    // count stays within the palette size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (MAX_COLORS < 32) |-> m_axis_tdata[10:6] <= COUNT_W'(MAX_COLORS))
        else $error("palette count above capacity");

endmodule

bind palette_build_and_index_map pbim_checker #(
    .MAX_COLORS (MAX_COLORS)
) u_pbim_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
